FILE: rtl/rmab_pkg.sv
package rmab_pkg;

   // Default sizes
   localparam int unsigned DEF_RING_DEPTH = 8;
   localparam int unsigned DEF_BAR_WIDTH  = 320;

   // Fixed field widths
   localparam int unsigned LEVEL_W   = 8;
   localparam int unsigned FILL_W    = 9;
   localparam int unsigned CSR_IDX_W = 1;

   // Register reset values (dBm)
   localparam logic signed [LEVEL_W-1:0] FAR_RESET   = -8'sd90;
   localparam logic signed [LEVEL_W-1:0] CLOSE_RESET = -8'sd30;

   // Register map
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FAR_LEVEL   = 1'b0,
      CSR_CLOSE_LEVEL = 1'b1
   } rmab_csr_type;

   // Sequencer states
   typedef enum logic [3:0] {
      ST_IDLE,
      ST_WRITE,
      ST_READ,
      ST_SUM_END,
      ST_AVG_LOAD,
      ST_AVG_DIV,
      ST_MAP,
      ST_FILL_LOAD,
      ST_FILL_DIV,
      ST_FINISH
   } rmab_state_type;

   // Controller to datapath
   typedef struct packed {
      logic load_item;
      logic write_entry;
      logic read_entry;
      logic avg_start;
      logic avg_take;
      logic map_level;
      logic fill_start;
      logic out_load;
   } rmab_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic write_done;
      logic read_last;
      logic div_busy;
   } rmab_sts_type;

endpackage

FILE: rtl/rssi_moving_average_bar_unit.sv
// Flow: a req_ transfer starts the ring writes (one for a push, RING_DEPTH for a refill), the
//   read sweep over the valid entries (the valid count), then two runs of the shared bit-serial
//   divider (width 17 at the default sizes), average first and bar fill second, then rsp_valid.
// Handshake: one item at a time; req_ready stays low from a transfer until its result is
//   loaded, and loading waits while a held result is not taken (rsp_ready low).
// Reset: synchronous, active high; clears pointer, count and sequencer, far/close reload -90/-30.
module rssi_moving_average_bar_unit #(
   parameter int unsigned RING_DEPTH = rmab_pkg::DEF_RING_DEPTH,
   parameter int unsigned BAR_WIDTH  = rmab_pkg::DEF_BAR_WIDTH
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  logic                                req_action,
   input  logic signed [rmab_pkg::LEVEL_W-1:0] req_sample,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output logic signed [rmab_pkg::LEVEL_W-1:0] rsp_smoothed_level,
   output logic [rmab_pkg::FILL_W-1:0]         rsp_fill_width,
   output logic                                rsp_is_close,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [rmab_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [rmab_pkg::LEVEL_W-1:0]        csr_data
);

   import rmab_pkg::*;

   rmab_cmd_type cmd;
   rmab_sts_type sts;
   logic         csr_we;

   // Register writes always complete in one transfer
   assign csr_ready = 1'b1;
   assign csr_we    = csr_valid & csr_ready;

   rmab_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   rmab_dp #(
      .RING_DEPTH (RING_DEPTH),
      .BAR_WIDTH  (BAR_WIDTH)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .sts                (sts),
      .req_action         (req_action),
      .req_sample         (req_sample),
      .csr_we             (csr_we),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .rsp_smoothed_level (rsp_smoothed_level),
      .rsp_fill_width     (rsp_fill_width),
      .rsp_is_close       (rsp_is_close)
   );

endmodule

FILE: rtl/rmab_ram.sv
module rmab_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // One write port, one registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/rmab_div.sv
module rmab_div #(
   parameter int unsigned DVD_W = 17,
   parameter int unsigned DVS_W = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic [DVD_W-1:0] dividend,
   input  logic [DVS_W-1:0] divisor,
   output logic             busy,
   output logic [DVD_W-1:0] quotient
);

   localparam int unsigned CNT_W = $clog2(DVD_W);

   logic             busy_ff, busy_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DVS_W-1:0] rem_ff, rem_in;
   logic [DVS_W-1:0] dvs_ff, dvs_in;
   logic [DVD_W-1:0] quo_ff, quo_in;
   logic [DVS_W:0]   trial;
   logic [DVS_W:0]   diff;
   logic             qbit;

   // Restoring division, one quotient bit per cycle, MSB first
   always_comb begin
      trial   = {rem_ff, quo_ff[DVD_W-1]};
      diff    = trial - {1'b0, dvs_ff};
      qbit    = ~diff[DVS_W];
      busy_in = busy_ff;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      dvs_in  = dvs_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rem_in  = '0;
         dvs_in  = divisor;
         quo_in  = dividend;
      end else if (busy_ff) begin
         rem_in  = qbit ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
         quo_in  = {quo_ff[DVD_W-2:0], qbit};
         cnt_in  = cnt_ff + CNT_W'(1);
         busy_in = (cnt_ff != CNT_W'(DVD_W - 1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      dvs_ff <= dvs_in;
      quo_ff <= quo_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/rmab_dp.sv
module rmab_dp #(
   parameter int unsigned RING_DEPTH = rmab_pkg::DEF_RING_DEPTH,
   parameter int unsigned BAR_WIDTH  = rmab_pkg::DEF_BAR_WIDTH
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  rmab_pkg::rmab_cmd_type                cmd,
   output rmab_pkg::rmab_sts_type                sts,
   input  logic                                  req_action,
   input  logic signed [rmab_pkg::LEVEL_W-1:0]   req_sample,
   input  logic                                  csr_we,
   input  logic [rmab_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [rmab_pkg::LEVEL_W-1:0]          csr_data,
   output logic signed [rmab_pkg::LEVEL_W-1:0]   rsp_smoothed_level,
   output logic [rmab_pkg::FILL_W-1:0]           rsp_fill_width,
   output logic                                  rsp_is_close
);

   import rmab_pkg::*;

   localparam int unsigned ADDR_W = $clog2(RING_DEPTH);
   localparam int unsigned CNT_W  = $clog2(RING_DEPTH + 1);
   localparam int unsigned SUM_W  = LEVEL_W + $clog2(RING_DEPTH);
   localparam int unsigned PROD_W = LEVEL_W + $clog2(BAR_WIDTH + 1);
   localparam int unsigned DVD_W  = (SUM_W > PROD_W) ? SUM_W : PROD_W;
   localparam int unsigned DVS_W  = (CNT_W > LEVEL_W) ? CNT_W : LEVEL_W;
   localparam int unsigned RNG_W  = LEVEL_W + 1;
   localparam int unsigned HALF_BAR = BAR_WIDTH / 2;

   // Configuration
   logic signed [LEVEL_W-1:0] far_ff, far_in;
   logic signed [LEVEL_W-1:0] close_ff, close_in;

   // Ring control
   logic [ADDR_W-1:0] idx_ff, idx_in;
   logic [ADDR_W-1:0] slot_ff, slot_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              rd_vld_ff;
   logic              idx_last;
   logic              write_done;

   // Item and arithmetic
   logic                      action_ff, action_in;
   logic signed [LEVEL_W-1:0] sample_ff, sample_in;
   logic signed [SUM_W-1:0]   acc_ff, acc_in;
   logic [SUM_W-1:0]          acc_abs;
   logic                      neg_ff, neg_in;
   logic signed [LEVEL_W-1:0] level_ff, level_in;
   logic [LEVEL_W-1:0]        q_low;
   logic signed [RNG_W-1:0]   range_w;
   logic signed [RNG_W-1:0]   offset_w;
   logic                      rng_ok;
   logic [LEVEL_W-1:0]        off_clamp;
   logic [PROD_W-1:0]         prod_ff, prod_in;
   logic [LEVEL_W-1:0]        rng_ff, rng_in;
   logic                      rng_ok_ff, rng_ok_in;
   logic [DVD_W-1:0]          fill_full;

   // Result register
   logic signed [LEVEL_W-1:0] lvl_out_ff, lvl_out_in;
   logic [FILL_W-1:0]         fill_out_ff, fill_out_in;
   logic                      close_out_ff, close_out_in;

   // Ring memory and divider hookup
   logic                ram_we;
   logic [ADDR_W-1:0]   ram_wr_addr;
   logic [LEVEL_W-1:0]  ram_wr_data;
   logic [LEVEL_W-1:0]  ram_rd_data;
   logic                div_start;
   logic [DVD_W-1:0]    div_dividend;
   logic [DVS_W-1:0]    div_divisor;
   logic                div_busy;
   logic [DVD_W-1:0]    div_quo;

   rmab_ram #(
      .WIDTH (LEVEL_W),
      .DEPTH (RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wr_addr),
      .wr_data (ram_wr_data),
      .rd_addr (idx_ff),
      .rd_data (ram_rd_data)
   );

   rmab_div #(
      .DVD_W (DVD_W),
      .DVS_W (DVS_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo)
   );

   // Status back to the sequencer
   assign idx_last   = (idx_ff == ADDR_W'(RING_DEPTH - 1));
   assign write_done = ~action_ff | idx_last;
   assign sts.write_done = write_done;
   assign sts.read_last  = ((CNT_W'(idx_ff) + CNT_W'(1)) == cnt_ff);
   assign sts.div_busy   = div_busy;

   // Ring write: refill sweeps every slot with far level, push writes one slot
   assign ram_we      = cmd.write_entry;
   assign ram_wr_addr = action_ff ? idx_ff : slot_ff;
   assign ram_wr_data = action_ff ? far_ff : sample_ff;

   // Divider operand select: average first, bar fill second
   assign acc_abs      = acc_ff[SUM_W-1] ? (~acc_ff + SUM_W'(1)) : acc_ff;
   assign div_start    = cmd.avg_start | cmd.fill_start;
   assign div_dividend = cmd.avg_start ? DVD_W'(acc_abs) : DVD_W'(prod_ff);
   assign div_divisor  = cmd.avg_start ? DVS_W'(cnt_ff) : DVS_W'(rng_ff);

   // Level mapping onto the bar
   assign q_low    = div_quo[LEVEL_W-1:0];
   assign range_w  = RNG_W'(close_ff) - RNG_W'(far_ff);
   assign offset_w = RNG_W'(level_ff) - RNG_W'(far_ff);
   assign rng_ok   = ~range_w[RNG_W-1] & (range_w != '0);
   assign fill_full = rng_ok_ff ? div_quo : '0;

   always_comb begin
      if (offset_w[RNG_W-1]) begin
         off_clamp = '0;
      end else if (offset_w[LEVEL_W-1:0] > range_w[LEVEL_W-1:0]) begin
         off_clamp = range_w[LEVEL_W-1:0];
      end else begin
         off_clamp = offset_w[LEVEL_W-1:0];
      end
   end

   function automatic logic idx_last_slot(input logic [ADDR_W-1:0] slot);
      idx_last_slot = (slot == ADDR_W'(RING_DEPTH - 1));
   endfunction

   // Next-state logic for all datapath registers except rd_vld_ff
   always_comb begin
      far_in       = far_ff;
      close_in     = close_ff;
      idx_in       = idx_ff;
      slot_in      = slot_ff;
      cnt_in       = cnt_ff;
      action_in    = action_ff;
      sample_in    = sample_ff;
      acc_in       = acc_ff;
      neg_in       = neg_ff;
      level_in     = level_ff;
      prod_in      = prod_ff;
      rng_in       = rng_ff;
      rng_ok_in    = rng_ok_ff;
      lvl_out_in   = lvl_out_ff;
      fill_out_in  = fill_out_ff;
      close_out_in = close_out_ff;

      if (csr_we) begin
         unique case (rmab_csr_type'(csr_index))
            CSR_FAR_LEVEL:   far_in   = csr_data;
            CSR_CLOSE_LEVEL: close_in = csr_data;
         endcase
      end

      if (cmd.load_item) begin
         action_in = req_action;
         sample_in = req_sample;
         idx_in    = '0;
         acc_in    = '0;
      end

      if (cmd.write_entry) begin
         idx_in = write_done ? '0 : idx_ff + ADDR_W'(1);
         if (write_done) begin
            if (action_ff) begin
               slot_in = '0;
               cnt_in  = CNT_W'(RING_DEPTH);
            end else begin
               slot_in = idx_last_slot(slot_ff) ? '0 : slot_ff + ADDR_W'(1);
               cnt_in  = (cnt_ff == CNT_W'(RING_DEPTH)) ? cnt_ff : cnt_ff + CNT_W'(1);
            end
         end
      end

      if (cmd.read_entry) begin
         idx_in = idx_ff + ADDR_W'(1);
      end

      // Read data arrives in the cycle after its address
      if (rd_vld_ff) begin
         acc_in = acc_ff + SUM_W'(signed'(ram_rd_data));
      end

      if (cmd.avg_start) begin
         neg_in = acc_ff[SUM_W-1];
      end

      // Truncation toward zero: divide the magnitude, restore the sign
      if (cmd.avg_take) begin
         level_in = neg_ff ? (~q_low + LEVEL_W'(1)) : q_low;
      end

      if (cmd.map_level) begin
         prod_in   = PROD_W'(off_clamp) * PROD_W'(BAR_WIDTH);
         rng_in    = range_w[LEVEL_W-1:0];
         rng_ok_in = rng_ok;
      end

      if (cmd.out_load) begin
         lvl_out_in   = level_ff;
         fill_out_in  = fill_full[FILL_W-1:0];
         close_out_in = (fill_full >= DVD_W'(HALF_BAR));
      end
   end

   // Control state and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         far_ff    <= FAR_RESET;
         close_ff  <= CLOSE_RESET;
         idx_ff    <= '0;
         slot_ff   <= '0;
         cnt_ff    <= '0;
         rd_vld_ff <= 1'b0;
      end else begin
         far_ff    <= far_in;
         close_ff  <= close_in;
         idx_ff    <= idx_in;
         slot_ff   <= slot_in;
         cnt_ff    <= cnt_in;
         rd_vld_ff <= cmd.read_entry;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      action_ff    <= action_in;
      sample_ff    <= sample_in;
      acc_ff       <= acc_in;
      neg_ff       <= neg_in;
      level_ff     <= level_in;
      prod_ff      <= prod_in;
      rng_ff       <= rng_in;
      rng_ok_ff    <= rng_ok_in;
      lvl_out_ff   <= lvl_out_in;
      fill_out_ff  <= fill_out_in;
      close_out_ff <= close_out_in;
   end

   assign rsp_smoothed_level = lvl_out_ff;
   assign rsp_fill_width     = fill_out_ff;
   assign rsp_is_close       = close_out_ff;

endmodule

FILE: rtl/rmab_ctrl.sv
module rmab_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output rmab_pkg::rmab_cmd_type cmd,
   input  rmab_pkg::rmab_sts_type sts
);

   import rmab_pkg::*;

   rmab_state_type state_ff, state_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic           out_free;

   // Result register can take a new value when empty or being drained
   assign out_free = ~rsp_valid_ff | rsp_ready;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE:      if (req_valid) state_in = ST_WRITE;
         ST_WRITE:     if (sts.write_done) state_in = ST_READ;
         ST_READ:      if (sts.read_last) state_in = ST_SUM_END;
         ST_SUM_END:   state_in = ST_AVG_LOAD;
         ST_AVG_LOAD:  state_in = ST_AVG_DIV;
         ST_AVG_DIV:   if (~sts.div_busy) state_in = ST_MAP;
         ST_MAP:       state_in = ST_FILL_LOAD;
         ST_FILL_LOAD: state_in = ST_FILL_DIV;
         ST_FILL_DIV:  if (~sts.div_busy) state_in = ST_FINISH;
         ST_FINISH:    if (out_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // Commands
   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready     = 1'b1;
            cmd.load_item = req_valid;
         end
         ST_WRITE:     cmd.write_entry = 1'b1;
         ST_READ:      cmd.read_entry  = 1'b1;
         ST_SUM_END:   cmd             = '0;
         ST_AVG_LOAD:  cmd.avg_start   = 1'b1;
         ST_AVG_DIV:   cmd.avg_take    = ~sts.div_busy;
         ST_MAP:       cmd.map_level   = 1'b1;
         ST_FILL_LOAD: cmd.fill_start  = 1'b1;
         ST_FILL_DIV:  cmd             = '0;
         ST_FINISH:    cmd.out_load    = out_free;
         default:      cmd             = '0;
      endcase
   end

   // Result valid flag
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.out_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

FILE: rtl/rmab_checker.sv
module rmab_checker #(
   parameter int unsigned BAR_WIDTH = rmab_pkg::DEF_BAR_WIDTH
) (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_ready,
   input logic                                rsp_valid,
   input logic                                rsp_ready,
   input logic signed [rmab_pkg::LEVEL_W-1:0] rsp_smoothed_level,
   input logic [rmab_pkg::FILL_W-1:0]         rsp_fill_width,
   input logic                                rsp_is_close
);

   import rmab_pkg::*;

   localparam int unsigned HALF_BAR = BAR_WIDTH / 2;
   localparam int unsigned FILL_MAX = (1 << FILL_W) - 1;

   // One item at a time: no second transfer straight after the first
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("req_ready high in the cycle after an input transfer");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_smoothed_level)
         && $stable(rsp_fill_width) && $stable(rsp_is_close))
      else $error("stalled result changed or dropped");

   // Close flag follows the fill length
   a_close_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (BAR_WIDTH > FILL_MAX) || (rsp_is_close == (rsp_fill_width >= HALF_BAR)))
      else $error("is_close disagrees with fill_width");

   // Fill never exceeds the bar
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (BAR_WIDTH > FILL_MAX) || (rsp_fill_width <= BAR_WIDTH))
      else $error("fill_width beyond bar width");

   // A new result only appears at the end of item processing
   a_rsp_from_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared while the block was idle");

endmodule

bind rssi_moving_average_bar_unit rmab_checker #(
   .BAR_WIDTH (BAR_WIDTH)
) u_rmab_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_valid),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_smoothed_level (rsp_smoothed_level),
   .rsp_fill_width     (rsp_fill_width),
   .rsp_is_close       (rsp_is_close)
);
